// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for writing clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, off while rst_n is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");

// Check that an expression never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`endif

// File: hw/rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// Shared constants, result codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package glu_pkg;

  // Field widths of the stream items.
  localparam int FieldWidth    = 32;
  localparam int AnsWidth      = 63;
  localparam int InDataWidth   = 2 * FieldWidth;
  localparam int OutDataWidth  = ((AnsWidth + 7) / 8) * 8;

  // Operand bits actually used (low bits of each field, two's complement).
  localparam int OperandWidth  = 32;
  localparam int ProdWidth     = 2 * OperandWidth;
  localparam int CntWidth      = $clog2(OperandWidth);

  typedef enum logic [1:0] {
    RES_GCD,
    RES_LCM,
    RES_ERR,
    RES_ZERO
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_lcm;
    logic     div_step;
    logic     swap;
    logic     mul;
    logic     res_load;
    res_sel_e res_sel;
  } glu_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic g_zero;
    logic div_last;
    logic lcm;
    logic neg;
  } glu_sts_t;

endpackage

// File: hw/rtl/glu_dpath.sv
// ----------------------------------------------------------------------------
// glu_dpath
// Operand magnitudes, bit-serial divider, multiplier and result register.
// ----------------------------------------------------------------------------
module glu_dpath import glu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  action_i,
  input  logic [FieldWidth-1:0] operand_a_i,
  input  logic [FieldWidth-1:0] operand_b_i,
  input  glu_cmd_t              cmd_i,
  output glu_sts_t              sts_o,
  output logic [AnsWidth-1:0]   answer_o,
  output logic                  negative_error_o
);

  logic [OperandWidth-1:0] a_op, b_op, a_mag, b_mag;
  logic                    a_sign, b_sign;

  // Euclid registers: magnitudes plus the sign each value carries.
  logic [OperandWidth-1:0] x_q, y_q, amag_q, bmag_q;
  logic                    sx_q, sy_q, lcm_q, neg_q;

  // Restoring divider.
  logic [OperandWidth-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [OperandWidth:0]   trial, diff;
  logic                    fits;
  logic [CntWidth-1:0]     cnt_q;

  logic [ProdWidth-1:0]          prod_q, prod_d;
  logic [ProdWidth+AnsWidth-1:0] prod_ext;
  logic [OperandWidth:0]         g_ext, g_neg, g_val;
  logic [AnsWidth-1:0]           res_val, answer_q;
  logic                          res_err, err_q;

  always_comb begin
    a_op   = operand_a_i[OperandWidth-1:0];
    b_op   = operand_b_i[OperandWidth-1:0];
    a_sign = a_op[OperandWidth-1];
    b_sign = b_op[OperandWidth-1];
    a_mag  = a_sign ? (~a_op + 1'b1) : a_op;
    b_mag  = b_sign ? (~b_op + 1'b1) : b_op;
  end

  always_comb begin
    trial = {rem_q, quo_q[OperandWidth-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[OperandWidth-1:0] : trial[OperandWidth-1:0];
    quo_d = {quo_q[OperandWidth-2:0], fits};
  end

  assign prod_d = quo_q * bmag_q;

  always_comb begin
    g_ext    = {1'b0, x_q};
    g_neg    = -g_ext;
    g_val    = sx_q ? g_neg : g_ext;
    prod_ext = {{AnsWidth{1'b0}}, prod_q};
    res_err  = 1'b0;
    case (cmd_i.res_sel)
      RES_GCD:  res_val = AnsWidth'($signed(g_val));
      RES_LCM:  res_val = prod_ext[AnsWidth-1:0];
      RES_ERR: begin
        res_val = '1;
        res_err = 1'b1;
      end
      default:  res_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= a_mag;
      y_q    <= b_mag;
      sx_q   <= a_sign;
      sy_q   <= b_sign;
      amag_q <= a_mag;
      bmag_q <= b_mag;
      lcm_q  <= action_i;
      neg_q  <= a_sign | b_sign;
    end
    // The remainder takes the sign of the dividend, so the signs swap too.
    if (cmd_i.swap) begin
      x_q  <= y_q;
      y_q  <= rem_q;
      sx_q <= sy_q;
      sy_q <= sx_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= cmd_i.div_lcm ? amag_q : x_q;
      dvs_q <= cmd_i.div_lcm ? x_q : y_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.res_load) begin
      answer_q <= res_val;
      err_q    <= res_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    sts_o.y_zero   = (y_q == '0);
    sts_o.g_zero   = (x_q == '0);
    sts_o.div_last = (cnt_q == CntWidth'(OperandWidth - 1));
    sts_o.lcm      = lcm_q;
    sts_o.neg      = neg_q;
  end

  assign answer_o         = answer_q;
  assign negative_error_o = err_q;

endmodule

// File: hw/rtl/glu_ctrl.sv
// ----------------------------------------------------------------------------
// glu_ctrl
// Sequencer for Euclid steps, the lcm divide and multiply, and result hand-off.
// ----------------------------------------------------------------------------
module glu_ctrl import glu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  input  glu_sts_t sts_i,
  output glu_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_GDIV = 7'b0000100,
    S_SWAP = 7'b0001000,
    S_LDIV = 7'b0010000,
    S_MUL  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e   state_q, state_d;
  res_sel_e sel_q, sel_d;
  logic     out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    s_ready_o   = 1'b0;
    cmd_o       = '0;
    cmd_o.res_sel = sel_q;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.lcm && sts_i.neg) begin
          sel_d   = RES_ERR;
          state_d = S_DONE;
        end else if (sts_i.y_zero) begin
          if (!sts_i.lcm) begin
            sel_d   = RES_GCD;
            state_d = S_DONE;
          end else if (sts_i.g_zero) begin
            sel_d   = RES_ZERO;
            state_d = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_lcm   = 1'b1;
            state_d         = S_LDIV;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.swap = 1'b1;
        state_d    = S_EVAL;
      end
      S_LDIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        sel_d     = RES_LCM;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // Wait for the output register to free up.
        if (!out_valid_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;

endmodule

// File: hw/rtl/gcd_lcm_unit.sv
// Flow: each accepted beat is loaded, then tested; each remainder step is a
// bit-serial divide, a swap and a test. For lcm a bit-serial divide by the gcd
// and one multiply follow.
// Throughput: one item at a time; a new beat is taken while a result waits.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Signed gcd by Euclid (truncating remainder) and lcm of two operands.
// ----------------------------------------------------------------------------
module gcd_lcm_unit import glu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input beat
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [InDataWidth-1:0]  s_axis_tdata_i,   // [31:0] operand_a, [63:32] operand_b
  input  logic                    s_axis_tuser_i,   // [0] action: 0 gcd, 1 lcm
  // Result beat
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OutDataWidth-1:0] m_axis_tdata_o,   // [62:0] answer, [63] zero
  output logic                    m_axis_tuser_o    // [0] negative_error
);

  glu_cmd_t            cmd;
  glu_sts_t            sts;
  logic [AnsWidth-1:0] answer;
  logic                neg_err;

  // Sequencer: walks Euclid steps over the shared divider, then for lcm
  // divides the first operand by the gcd and multiplies by the second.
  glu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath works on magnitudes; the sign of the gcd follows the operand
  // that ends up last, since each remainder keeps its dividend's sign.
  glu_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (s_axis_tuser_i),
    .operand_a_i      (s_axis_tdata_i[FieldWidth-1:0]),
    .operand_b_i      (s_axis_tdata_i[InDataWidth-1:FieldWidth]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .answer_o         (answer),
    .negative_error_o (neg_err)
  );

  // Pad the answer up to whole bytes.
  assign m_axis_tdata_o = {{(OutDataWidth - AnsWidth){1'b0}}, answer};
  assign m_axis_tuser_o = neg_err;

endmodule

// File: hw/rtl/glu_checker.sv
// ----------------------------------------------------------------------------
// glu_checker
// Port-level checks on the gcd/lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_i,
  input logic        m_axis_tuser_i
);

  // A pending result stays up until it is taken.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)

  // Once a beat is taken the unit is busy with it.
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)

  // A rejected lcm always answers minus one.
  `ASSERT_PROP(a_err_answer, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i[62:0] == {63{1'b1}})

  // Padding bit stays clear.
  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tdata_i[63])

endmodule

bind gcd_lcm_unit glu_checker u_glu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// File: verif/tb_gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// tb_gcd_lcm_unit
// Self-checking bench for the gcd/lcm unit. Drives operand beats on the input
// stream with random gaps and back-pressure, computes each expected answer
// with an in-bench Euclid model, and compares every result beat against the
// oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_gcd_lcm_unit;
  import glu_pkg::*;

  typedef enum logic {
    ACT_GCD = 1'b0,
    ACT_LCM = 1'b1
  } action_e;

  // One expected result, kept with the operands that produced it.
  typedef struct {
    logic [AnsWidth-1:0]   answer;
    logic                  neg_err;
    action_e               act;
    logic [FieldWidth-1:0] op_a;
    logic [FieldWidth-1:0] op_b;
  } gcd_lcm_result_t;

  localparam int unsigned RUN_LIMIT    = 3_000_000;  // cycles before giving up
  localparam int unsigned SETTLE_WAIT  = 1700;       // worst item latency and some
  localparam int unsigned PHASE_ITEMS  = 117;
  localparam int unsigned MAX_REPORTS  = 100;

  localparam logic [FieldWidth-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [FieldWidth-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [FieldWidth-1:0] NEG_ONE = 32'hffff_ffff;
  // Consecutive Fibonacci numbers: the longest Euclid chain in range.
  localparam logic [FieldWidth-1:0] FIB_HI  = 32'd1836311903;
  localparam logic [FieldWidth-1:0] FIB_LO  = 32'd1134903170;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    s_axis_tvalid_i  = 1'b0;
  logic                    s_axis_tready_o;
  logic [InDataWidth-1:0]  s_axis_tdata_i   = '0;
  logic                    s_axis_tuser_i   = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i  = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata_o;
  logic                    m_axis_tuser_o;

  gcd_lcm_result_t pending_results[$];
  int unsigned     mismatch_count   = 0;
  int unsigned     cycle_count      = 0;
  int unsigned     sender_idle_pct  = 0;
  int unsigned     receiver_idle_pct = 0;

  gcd_lcm_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [31:0] operand_a, [63:32] operand_b
    .s_axis_tuser_i  (s_axis_tuser_i),   // [0] action
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [62:0] answer, [63] zero pad
    .m_axis_tuser_o  (m_axis_tuser_o)    // [0] negative_error
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Throttle the result side.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Euclid with truncating remainder; the remainder keeps the dividend's sign.
  function automatic longint euclid_gcd(input longint x_in, input longint y_in);
    longint x;
    longint y;
    longint rem;
    x = x_in;
    y = y_in;
    while (y != 0) begin
      rem = x % y;
      x   = y;
      y   = rem;
    end
    return x;
  endfunction

  function automatic gcd_lcm_result_t predict_result(input action_e act,
                                                     input logic [FieldWidth-1:0] a_raw,
                                                     input logic [FieldWidth-1:0] b_raw);
    gcd_lcm_result_t res;
    longint a;
    longint b;
    longint g;
    longint value;
    a = longint'(signed'(a_raw[OperandWidth-1:0]));
    b = longint'(signed'(b_raw[OperandWidth-1:0]));
    res.neg_err = 1'b0;
    if (act == ACT_GCD) begin
      value = euclid_gcd(a, b);
    end else if (a < 0 || b < 0) begin
      value       = -1;
      res.neg_err = 1'b1;
    end else begin
      g = euclid_gcd(a, b);
      // Both zero: no division, answer zero.
      value = (g == 0) ? 0 : (a * b) / g;
    end
    res.answer = value[AnsWidth-1:0];
    res.act    = act;
    res.op_a   = a_raw;
    res.op_b   = b_raw;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  // Check every result beat against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    gcd_lcm_result_t exp_res;
    logic [AnsWidth-1:0] got_answer;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_answer = m_axis_tdata_o[AnsWidth-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result answer=%h err=%b",
                                  got_answer, m_axis_tuser_o));
      end else begin
        exp_res = pending_results.pop_front();
        if (got_answer !== exp_res.answer) begin
          report_mismatch($sformatf("%s(%h,%h) answer %h, want %h", exp_res.act.name(),
                                    exp_res.op_a, exp_res.op_b, got_answer,
                                    exp_res.answer));
        end
        if (m_axis_tuser_o !== exp_res.neg_err) begin
          report_mismatch($sformatf("%s(%h,%h) negative_error %b, want %b",
                                    exp_res.act.name(), exp_res.op_a, exp_res.op_b,
                                    m_axis_tuser_o, exp_res.neg_err));
        end
      end
    end
  end

  // Present one operand beat, hold it until taken, then queue its answer.
  task automatic send_operands(input action_e act, input logic [FieldWidth-1:0] a,
                               input logic [FieldWidth-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    s_axis_tuser_i  <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_result(act, a, b));
  endtask

  // Drop valid and hold off until every queued answer has come back.
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FieldWidth-1:0] pick_operand();
    logic [FieldWidth-1:0] v;
    case ($urandom_range(5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 200);
      3: v = $urandom_range(0, 1 << 20);
      4: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 32'd1;
          2: v = NEG_ONE;
          3: v = INT_MAX;
          default: v = INT_MIN;
        endcase
      end
      default: v = $urandom_range(0, INT_MAX);
    endcase
    // Flip some toward negative so lcm sees its reject path now and then.
    if ($urandom_range(7) == 0) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic test_gcd_corners();
    send_operands(ACT_GCD, '0, '0);
    send_operands(ACT_GCD, INT_MIN, '0);      // second zero: first passes through
    send_operands(ACT_GCD, '0, INT_MIN);
    send_operands(ACT_GCD, INT_MIN, NEG_ONE);
    send_operands(ACT_GCD, INT_MIN, INT_MIN);
    send_operands(ACT_GCD, INT_MAX, INT_MIN);
    send_operands(ACT_GCD, -32'sd12, 32'sd18);
    send_operands(ACT_GCD, 32'sd12, -32'sd18);
    send_operands(ACT_GCD, -32'sd48, -32'sd18);
    send_operands(ACT_GCD, FIB_HI, FIB_LO);   // longest remainder chain
    send_operands(ACT_GCD, INT_MAX, INT_MAX);
    send_operands(ACT_GCD, 32'd1, NEG_ONE);
  endtask

  task automatic test_lcm_corners();
    send_operands(ACT_LCM, '0, '0);           // both zero: answer zero
    send_operands(ACT_LCM, '0, 32'd7);
    send_operands(ACT_LCM, 32'd7, '0);
    send_operands(ACT_LCM, NEG_ONE, 32'd5);   // negative operand rejects
    send_operands(ACT_LCM, 32'd5, NEG_ONE);
    send_operands(ACT_LCM, INT_MIN, INT_MIN);
    send_operands(ACT_LCM, '0, INT_MIN);
    send_operands(ACT_LCM, INT_MAX, INT_MAX - 1);  // largest product
    send_operands(ACT_LCM, INT_MAX, INT_MAX);
    send_operands(ACT_LCM, 32'd12, 32'd18);
    send_operands(ACT_LCM, FIB_HI, FIB_LO);
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [FieldWidth-1:0] a;
    logic [FieldWidth-1:0] b;
    int unsigned factor;
    action_e act;
    repeat (count) begin
      act = action_e'($urandom_range(1));
      if ($urandom_range(2) == 0) begin
        // Shared factor so the gcd is often something other than one.
        factor = $urandom_range(1, 5000);
        a = factor * $urandom_range(0, 400000);
        b = factor * $urandom_range(0, 400000);
        if ($urandom_range(5) == 0) a = -a;
        if ($urandom_range(5) == 0) b = -b;
      end else begin
        a = pick_operand();
        b = pick_operand();
      end
      send_operands(act, a, b);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender mostly busy, receiver stalls often.
    sender_idle_pct   = 10;
    receiver_idle_pct = 61;
    test_gcd_corners();
    test_lcm_corners();
    test_random_mix(PHASE_ITEMS);
    wait_for_results();

    // Swap: sparse sender, eager-ish receiver.
    sender_idle_pct   = 61;
    receiver_idle_pct = 10;
    test_random_mix(PHASE_ITEMS);
    wait_for_results();

    // Full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_mix(PHASE_ITEMS);
    wait_for_results();

    // Catch any stray result beat after the last one.
    repeat (SETTLE_WAIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: gcd_lcm_unit.f
+incdir+hw/rtl
hw/rtl/glu_pkg.sv
hw/rtl/glu_dpath.sv
hw/rtl/glu_ctrl.sv
hw/rtl/gcd_lcm_unit.sv
hw/rtl/glu_checker.sv
verif/tb_gcd_lcm_unit.sv
